// ===== rtl/core/tvg_pkg.sv =====
package tvg_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int RADIUS_W   = 15;

  // Register reset values.
  localparam logic [RADIUS_W-1:0] MAJOR_RESET = 15'd4096;
  localparam logic [RADIUS_W-1:0] MINOR_RESET = 15'd1229;
  localparam int RADIAL_RESET  = 32;
  localparam int TUBULAR_RESET = 16;

  // Register stages of the sine evaluator.
  localparam int SINE_LAT = 7;

  // Odd Taylor coefficients of sin(pi/2 * t) in Q28, lowest order first.
  localparam logic [28:0] SIN_COEF [5] = '{
    29'd421657428, 29'd173399667, 29'd21392326, 29'd1256749, 29'd43068
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAJOR_RADIUS     = 2'd0,
    CFG_MINOR_RADIUS     = 2'd1,
    CFG_RADIAL_SEGMENTS  = 2'd2,
    CFG_TUBULAR_SEGMENTS = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] ring_step;
    logic [7:0] tube_step;
  } vtx_in_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [12:0]        red;
    logic [12:0]        green;
    logic [12:0]        blue;
    logic [15:0]        vertex_index;
    logic [15:0]        next_row_index;
    logic               quad_valid;
    logic               in_range;
  } vtx_out_t;

  // Grid bookkeeping that rides along the arithmetic pipeline.
  typedef struct packed {
    logic [15:0] vertex_index;
    logic [15:0] next_row_index;
    logic        quad_valid;
    logic        in_range;
  } vtx_side_t;

endpackage

// ===== rtl/core/tvg_sine.sv =====
module tvg_sine #(
  parameter int PHASE_BITS = 12
) (
  input  logic                  clk_i,
  input  logic [PHASE_BITS-1:0] phase_i,
  output logic signed [15:0]    sine_o
);

  localparam int FRAC_W = PHASE_BITS - 2;

  logic [1:0]         quad;
  logic [15:0]        t_raw;
  logic [16:0]        t_in;
  logic [16:0]        t_q   [1:6];
  logic               neg_q [1:6];
  logic [16:0]        sq_q  [2:5];
  logic [28:0]        acc_q [3:6];
  logic [28:0]        acc_d [3:6];
  logic [28:0]        mul_a [3:6];
  logic [45:0]        horner_prod [3:6];
  logic [33:0]        sq_prod;
  logic [45:0]        fin_prod;
  logic [29:0]        fin_scaled;
  logic [15:0]        fin_round;
  logic [14:0]        mag;
  logic signed [15:0] sine_d;
  logic signed [15:0] sine_q;

  // Split the phase into quadrant and a Q16 fraction; odd quadrants run backward.
  assign quad  = phase_i[PHASE_BITS-1 -: 2];
  assign t_raw = {phase_i[FRAC_W-1:0], {(16-FRAC_W){1'b0}}};
  assign t_in  = quad[0] ? (17'h10000 - {1'b0, t_raw}) : {1'b0, t_raw};

  // Horner evaluation, one multiply per stage.
  always_comb begin
    sq_prod  = 34'(t_q[1]) * 34'(t_q[1]);
    mul_a[3] = tvg_pkg::SIN_COEF[4];
    for (int p = 4; p <= 6; p++) begin
      mul_a[p] = acc_q[p-1];
    end
    for (int p = 3; p <= 6; p++) begin
      horner_prod[p] = 46'(mul_a[p]) * 46'(sq_q[p-1]);
      acc_d[p]       = tvg_pkg::SIN_COEF[6-p] - 29'(horner_prod[p] >> 16);
    end
    fin_prod   = 46'(acc_q[6]) * 46'(t_q[6]);
    fin_scaled = 30'(fin_prod >> 16);
    fin_round  = 16'((fin_scaled + 30'd8192) >> 14);
    mag        = (fin_round > 16'd16384) ? 15'd16384 : fin_round[14:0];
    sine_d     = neg_q[6] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  // Pipeline registers of the evaluator.
  always_ff @(posedge clk_i) begin
    t_q[1]   <= t_in;
    neg_q[1] <= quad[1];
    for (int p = 2; p <= 6; p++) begin
      t_q[p]   <= t_q[p-1];
      neg_q[p] <= neg_q[p-1];
    end
    sq_q[2] <= sq_prod[32:16];
    for (int p = 3; p <= 5; p++) begin
      sq_q[p] <= sq_q[p-1];
    end
    for (int p = 3; p <= 6; p++) begin
      acc_q[p] <= acc_d[p];
    end
    sine_q <= sine_d;
  end

  assign sine_o = sine_q;

endmodule

// ===== rtl/core/torus_vertex_generator.sv =====
// Path: an accepted transaction passes the divider entry register, the divider stages, the sine
//   pipeline, then the ring, projection and output registers, and shows on done_o and result_o.
// One vertex per clock unless busy; the phase divider retires four quotient bits per stage.
// The sine path is a seven-stage polynomial pipeline; busy is high only in the cycle after reset.
// Reset clears the valid line and loads the configuration registers with their defaults.
module torus_vertex_generator #(
  parameter int PHASE_BITS   = 12,
  parameter int SEGMENT_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  tvg_pkg::vtx_in_t                 item_i,
  output logic                             done_o,
  output tvg_pkg::vtx_out_t                result_o,
  input  logic                             cfg_we_i,
  input  logic [tvg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tvg_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int DIV_W      = SEGMENT_BITS + PHASE_BITS;
  localparam int DIV_RW     = SEGMENT_BITS + DIV_W;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = (DIV_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int IDX_W      = 2 * SEGMENT_BITS + 2;
  localparam int POS_P2     = DIV_STAGES + tvg_pkg::SINE_LAT + 2;
  localparam int LATENCY    = POS_P2 + 1;
  localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);

  logic [tvg_pkg::RADIUS_W-1:0] major_q;
  logic [tvg_pkg::RADIUS_W-1:0] minor_q;
  logic [SEGMENT_BITS-1:0]      radial_q;
  logic [SEGMENT_BITS-1:0]      tubular_q;
  logic [SEGMENT_BITS-1:0]      rad_eff;
  logic [SEGMENT_BITS-1:0]      tub_eff;
  logic                         busy_q;
  logic                         accept;

  logic [SEGMENT_BITS-1:0]      seg_i;
  logic [SEGMENT_BITS-1:0]      seg_j;
  logic [SEGMENT_BITS:0]        tub_p1;
  logic [IDX_W-1:0]             idx_full;
  tvg_pkg::vtx_side_t           side_d;

  logic [DIV_RW-1:0]            div_u_d [DIV_STAGES+1];
  logic [DIV_RW-1:0]            div_v_d [DIV_STAGES+1];
  logic [DIV_RW-1:0]            div_u_q [DIV_STAGES+1];
  logic [DIV_RW-1:0]            div_v_q [DIV_STAGES+1];

  logic                         vld_q  [POS_P2+1];
  tvg_pkg::vtx_side_t           side_q [POS_P2+1];

  logic [PHASE_BITS-1:0]        phase_u;
  logic [PHASE_BITS-1:0]        phase_v;
  logic signed [15:0]           sin_u;
  logic signed [15:0]           cos_u;
  logic signed [15:0]           sin_v;
  logic signed [15:0]           cos_v;

  logic signed [31:0]           w_q;
  logic signed [31:0]           zp_q;
  logic signed [15:0]           cu_q;
  logic signed [15:0]           su_q;
  logic signed [15:0]           sv_q;
  logic signed [47:0]           px_q;
  logic signed [47:0]           py_q;
  logic signed [15:0]           z_q;
  logic [12:0]                  red_q;
  logic [12:0]                  green_q;
  logic [12:0]                  blue_q;
  logic                         done_q;
  tvg_pkg::vtx_out_t            result_q;

  // One restoring division step: shift in a dividend bit, subtract when it fits.
  function automatic logic [DIV_RW-1:0] div_step(input logic [DIV_RW-1:0] ra,
                                                 input logic [SEGMENT_BITS-1:0] n);
    logic [SEGMENT_BITS:0] trial;
    logic [SEGMENT_BITS:0] diff;
    trial = {ra[DIV_RW-1:DIV_W], ra[DIV_W-1]};
    diff  = trial - {1'b0, n};
    if (trial >= {1'b0, n}) begin
      div_step = {diff[SEGMENT_BITS-1:0], ra[DIV_W-2:0], 1'b1};
    end else begin
      div_step = {trial[SEGMENT_BITS-1:0], ra[DIV_W-2:0], 1'b0};
    end
  endfunction

  // Round half away from zero by sh bits, then clamp to 16 signed bits.
  function automatic logic signed [15:0] round_sat(input logic signed [47:0] v,
                                                   input int unsigned sh);
    logic signed [47:0] r;
    r = (v + (48'sd1 <<< (sh - 1)) - $signed({47'd0, v[47]})) >>> sh;
    if (r > 48'sd32767) begin
      round_sat = 16'sh7fff;
    end else if (r < -48'sd32768) begin
      round_sat = 16'sh8000;
    end else begin
      round_sat = r[15:0];
    end
  endfunction

  // Map a Q1.14 value onto an unsigned Q1.12 color channel.
  function automatic logic [12:0] color_of(input logic signed [15:0] c);
    logic [16:0] s;
    s = {c[15], c} + 17'd16388;
    color_of = s[15:3];
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      major_q   <= tvg_pkg::MAJOR_RESET;
      minor_q   <= tvg_pkg::MINOR_RESET;
      radial_q  <= SEGMENT_BITS'(tvg_pkg::RADIAL_RESET);
      tubular_q <= SEGMENT_BITS'(tvg_pkg::TUBULAR_RESET);
    end else if (cfg_we_i) begin
      case (tvg_pkg::cfg_idx_e'(cfg_idx_i))
        tvg_pkg::CFG_MAJOR_RADIUS:     major_q   <= cfg_data_i;
        tvg_pkg::CFG_MINOR_RADIUS:     minor_q   <= cfg_data_i;
        tvg_pkg::CFG_RADIAL_SEGMENTS:  radial_q  <= cfg_data_i[SEGMENT_BITS-1:0];
        tvg_pkg::CFG_TUBULAR_SEGMENTS: tubular_q <= cfg_data_i[SEGMENT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // A segment count of zero behaves as one.
  assign rad_eff = (radial_q == '0) ? SEGMENT_BITS'(1) : radial_q;
  assign tub_eff = (tubular_q == '0) ? SEGMENT_BITS'(1) : tubular_q;

  // The block is busy in the cycle after reset and never stalls after that.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy   = busy_q;
  assign accept = start && !busy_q;

  // Entry: mesh indices and grid flags.
  always_comb begin
    seg_i    = item_i.ring_step[SEGMENT_BITS-1:0];
    seg_j    = item_i.tube_step[SEGMENT_BITS-1:0];
    tub_p1   = {1'b0, tub_eff} + (SEGMENT_BITS+1)'(1);
    idx_full = IDX_W'(seg_i) * IDX_W'(tub_p1) + IDX_W'(seg_j);
    side_d.vertex_index   = 16'(idx_full);
    side_d.next_row_index = side_d.vertex_index + 16'(tub_p1);
    side_d.quad_valid     = (seg_i < rad_eff) && (seg_j < tub_eff);
    side_d.in_range       = (seg_i <= rad_eff) && (seg_j <= tub_eff);
  end

  // The rounded phase dividends enter the divider; each stage retires up to four quotient bits.
  always_comb begin
    div_u_d[0] = {SEGMENT_BITS'(0), {seg_i, {PHASE_BITS{1'b0}}} + DIV_W'(rad_eff >> 1)};
    div_v_d[0] = {SEGMENT_BITS'(0), {seg_j, {PHASE_BITS{1'b0}}} + DIV_W'(tub_eff >> 1)};
    for (int s = 1; s <= DIV_STAGES; s++) begin
      div_u_d[s] = div_u_q[s-1];
      div_v_d[s] = div_v_q[s-1];
      for (int b = 0; b < DIV_STEPS; b++) begin
        if ((s - 1) * DIV_STEPS + b < DIV_W) begin
          div_u_d[s] = div_step(div_u_d[s], rad_eff);
          div_v_d[s] = div_step(div_v_d[s], tub_eff);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s <= DIV_STAGES; s++) begin
      div_u_q[s] <= div_u_d[s];
      div_v_q[s] <= div_v_d[s];
    end
  end

  // Valid bits and grid bookkeeping travel alongside the arithmetic.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= POS_P2; k++) begin
        vld_q[k] <= 1'b0;
      end
      done_q <= 1'b0;
    end else begin
      vld_q[0] <= accept;
      for (int k = 1; k <= POS_P2; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
      done_q <= vld_q[POS_P2];
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int k = 1; k <= POS_P2; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  // Sine and cosine of both angles; the quotient modulo a full turn is the phase.
  assign phase_u = div_u_q[DIV_STAGES][PHASE_BITS-1:0];
  assign phase_v = div_v_q[DIV_STAGES][PHASE_BITS-1:0];

  tvg_sine #(.PHASE_BITS(PHASE_BITS)) u_sin_u (
    .clk_i   (clk_i),
    .phase_i (phase_u),
    .sine_o  (sin_u)
  );

  tvg_sine #(.PHASE_BITS(PHASE_BITS)) u_cos_u (
    .clk_i   (clk_i),
    .phase_i (phase_u + QUARTER),
    .sine_o  (cos_u)
  );

  tvg_sine #(.PHASE_BITS(PHASE_BITS)) u_sin_v (
    .clk_i   (clk_i),
    .phase_i (phase_v),
    .sine_o  (sin_v)
  );

  tvg_sine #(.PHASE_BITS(PHASE_BITS)) u_cos_v (
    .clk_i   (clk_i),
    .phase_i (phase_v + QUARTER),
    .sine_o  (cos_v)
  );

  // Ring distance and tube height.
  always_ff @(posedge clk_i) begin
    w_q  <= $signed({3'b000, major_q, 14'd0}) + $signed({1'b0, minor_q}) * cos_v;
    zp_q <= $signed({1'b0, minor_q}) * sin_v;
    cu_q <= cos_u;
    su_q <= sin_u;
    sv_q <= sin_v;
  end

  // Project onto x and y; finish z and the colors.
  always_ff @(posedge clk_i) begin
    px_q    <= w_q * cu_q;
    py_q    <= w_q * su_q;
    z_q     <= round_sat(48'(zp_q), 14);
    red_q   <= color_of(cu_q);
    green_q <= color_of(su_q);
    blue_q  <= color_of(sv_q);
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    result_q.pos_x          <= round_sat(px_q, 28);
    result_q.pos_y          <= round_sat(py_q, 28);
    result_q.pos_z          <= z_q;
    result_q.red            <= red_q;
    result_q.green          <= green_q;
    result_q.blue           <= blue_q;
    result_q.vertex_index   <= side_q[POS_P2].vertex_index;
    result_q.next_row_index <= side_q[POS_P2].next_row_index;
    result_q.quad_valid     <= side_q[POS_P2].quad_valid;
    result_q.in_range       <= side_q[POS_P2].in_range;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

`ifndef SYNTHESIS
  // Every accepted transaction produces exactly one result after the fixed latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(LATENCY + 1) done_o)
    else $error("accepted vertex did not produce a result on time");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY + 1))
    else $error("result strobe without a matching accepted vertex");

  // A quad can only start at a point inside the grid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.quad_valid) |-> result_o.in_range)
    else $error("quad flagged for a point outside the grid");

  // Color channels stay within one in Q1.12.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.red <= 13'd4096) && (result_o.green <= 13'd4096) &&
               (result_o.blue <= 13'd4096))
    else $error("color channel out of range");
`endif

endmodule
